FILE: rtl/xmr_pkg.sv
`timescale 1ns / 1ps

package xmr_pkg;

  localparam logic [7:0] B_SOH    = 8'h01;
  localparam logic [7:0] B_STX    = 8'h02;
  localparam logic [7:0] B_EOT    = 8'h04;
  localparam logic [7:0] B_ACK    = 8'h06;
  localparam logic [7:0] B_NAK    = 8'h15;
  localparam logic [7:0] B_CAN    = 8'h18;
  localparam logic [7:0] B_CRCREQ = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [10:0] BLK_SIZE_SHORT = 11'd128;
  localparam logic [10:0] BLK_SIZE_LONG  = 11'd1024;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TICK    = 2'd2,
    OP_CARRIER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_MODE       = 2'd0,
    REG_HDR_TMO    = 2'd1,
    REG_BYTE_TMO   = 2'd2,
    REG_MAX_ERRORS = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    BEND_NONE    = 2'd0,
    BEND_COMMIT  = 2'd1,
    BEND_DISCARD = 2'd2
  } bend_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_RUNNING   = 3'd1,
    ST_SUCCESS   = 3'd2,
    ST_CARRIER   = 3'd3,
    ST_ERRORS    = 3'd4,
    ST_CANCELLED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_HDR     = 4'd1,
    PH_BNUM    = 4'd2,
    PH_BCMP    = 4'd3,
    PH_DATA    = 4'd4,
    PH_CRCHI   = 4'd5,
    PH_CKLO    = 4'd6,
    PH_PURGE   = 4'd7,
    PH_OK      = 4'd8,
    PH_CARRIER = 4'd9,
    PH_ERRORS  = 4'd10,
    PH_CANCEL  = 4'd11
  } phase_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic is_running(input phase_t ph);
    return (ph >= PH_HDR) && (ph <= PH_PURGE);
  endfunction

  function automatic status_t phase_status(input phase_t ph);
    status_t s;
    case (ph)
      PH_IDLE:    s = ST_IDLE;
      PH_OK:      s = ST_SUCCESS;
      PH_CARRIER: s = ST_CARRIER;
      PH_ERRORS:  s = ST_ERRORS;
      PH_CANCEL:  s = ST_CANCELLED;
      default:    s = is_running(ph) ? ST_RUNNING : ST_CANCELLED;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/xmodem_receiver_top.sv
`timescale 1ns / 1ps

// xmodem receiver for checksum, crc-16 and 1k block modes. every input word
// (start, received byte, one-second tick or carrier loss) yields exactly one
// result word, registered in the cycle after it is accepted; the whole protocol step,
// including the byte-wide crc update, is combinational between the input handshake
// and the result register, so a new word is taken every cycle as long as the
// result side keeps up (in_ready follows out_ready whenever a result is held).
// payload bytes stream out on out_data_* and are committed or discarded through
// out_block_end when the block check completes or the block is abandoned. configuration
// writes take effect on the next cycle and belong between transfers.
module xmodem_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_valid,
  output logic [7:0]  out_send_byte,
  output logic        out_data_valid,
  output logic [7:0]  out_data_byte,
  output logic [1:0]  out_block_end,
  output logic [2:0]  out_transfer_status,
  output logic [15:0] out_good_blocks,
  output logic [7:0]  out_error_count
);

  logic [1:0] mode_r;
  logic [7:0] hdr_tmo_r, byte_tmo_r, max_err_r;

  xmr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  exp_blk_r, exp_blk_nxt;
  logic [7:0]  rcv_blk_r, rcv_blk_nxt;
  logic [10:0] byte_cnt_r, byte_cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [7:0]  attempts_r, attempts_nxt;
  logic [7:0]  silence_r, silence_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [15:0] good_r, good_nxt;

  logic        out_valid_r;
  logic        sv_r, dv_r;
  logic [7:0]  sb_r, db_r;
  logic [1:0]  bend_r;
  logic [2:0]  st_r;
  logic [15:0] good_out_r;
  logic [7:0]  err_out_r;

  logic        sv, dv;
  logic [7:0]  sb, db;
  xmr_pkg::bend_t bend;

  logic        accept;
  logic        crc_mode, long_blk, streamed, ok;
  logic [7:0]  opening, hdr_byte, limit, sil_inc;
  logic [10:0] blk_size, cnt_inc;
  logic [15:0] crc_new;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign crc_mode  = (mode_r != 2'd0);
  assign long_blk  = mode_r[1];
  assign opening   = crc_mode ? xmr_pkg::B_CRCREQ : xmr_pkg::B_NAK;
  assign hdr_byte  = long_blk ? xmr_pkg::B_STX : xmr_pkg::B_SOH;
  assign blk_size  = long_blk ? xmr_pkg::BLK_SIZE_LONG : xmr_pkg::BLK_SIZE_SHORT;
  assign streamed  = (phase_r == xmr_pkg::PH_DATA && byte_cnt_r != 11'd0) ||
                     phase_r == xmr_pkg::PH_CRCHI || phase_r == xmr_pkg::PH_CKLO;
  assign limit     = (phase_r == xmr_pkg::PH_HDR) ? hdr_tmo_r : byte_tmo_r;
  assign sil_inc   = (silence_r == 8'hFF) ? silence_r : silence_r + 8'd1;
  assign cnt_inc   = byte_cnt_r + 11'd1;
  assign crc_new   = xmr_pkg::crc_update(crc_r, in_rx_byte);
  assign ok        = crc_mode ? ({crc_hi_r, in_rx_byte} == crc_r) : (in_rx_byte == sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 2'd1;
      hdr_tmo_r  <= 8'd10;
      byte_tmo_r <= 8'd2;
      max_err_r  <= 8'd10;
    end else if (cfg_we) begin
      case (xmr_pkg::reg_idx_t'(cfg_index))
        xmr_pkg::REG_MODE:       mode_r     <= cfg_wdata[1:0];
        xmr_pkg::REG_HDR_TMO:    hdr_tmo_r  <= cfg_wdata;
        xmr_pkg::REG_BYTE_TMO:   byte_tmo_r <= cfg_wdata;
        xmr_pkg::REG_MAX_ERRORS: max_err_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic hdr_enter;
    logic [7:0] att_base;
    hdr_enter    = 1'b0;
    att_base     = attempts_r;
    phase_nxt    = phase_r;
    exp_blk_nxt  = exp_blk_r;
    rcv_blk_nxt  = rcv_blk_r;
    byte_cnt_nxt = byte_cnt_r;
    crc_nxt      = crc_r;
    sum_nxt      = sum_r;
    crc_hi_nxt   = crc_hi_r;
    attempts_nxt = attempts_r;
    silence_nxt  = silence_r;
    pend_nxt     = pend_r;
    good_nxt     = good_r;
    sv   = 1'b0;
    sb   = 8'h00;
    dv   = 1'b0;
    db   = 8'h00;
    bend = xmr_pkg::BEND_NONE;

    case (xmr_pkg::op_t'(in_op))
      xmr_pkg::OP_START: begin
        if (streamed) bend = xmr_pkg::BEND_DISCARD;
        exp_blk_nxt  = 8'd1;
        rcv_blk_nxt  = 8'd0;
        byte_cnt_nxt = 11'd0;
        crc_nxt      = 16'h0000;
        sum_nxt      = 8'h00;
        crc_hi_nxt   = 8'h00;
        pend_nxt     = 8'h00;
        good_nxt     = 16'h0000;
        att_base     = 8'h00;
        attempts_nxt = 8'h00;
        sv = 1'b1;
        sb = opening;
        hdr_enter = 1'b1;
      end
      xmr_pkg::OP_CARRIER: begin
        if (xmr_pkg::is_running(phase_r)) begin
          if (streamed) bend = xmr_pkg::BEND_DISCARD;
          sv = 1'b1;
          if (phase_r == xmr_pkg::PH_HDR) sb = opening;
          else if (phase_r == xmr_pkg::PH_PURGE) sb = pend_r;
          else sb = xmr_pkg::B_NAK;
          phase_nxt = xmr_pkg::PH_CARRIER;
        end
      end
      xmr_pkg::OP_TICK: begin
        if (xmr_pkg::is_running(phase_r)) begin
          silence_nxt = sil_inc;
          if (sil_inc >= limit) begin
            silence_nxt = 8'h00;
            if (phase_r == xmr_pkg::PH_HDR) begin
              pend_nxt  = opening;
              phase_nxt = xmr_pkg::PH_PURGE;
            end else if (phase_r == xmr_pkg::PH_PURGE) begin
              sv = 1'b1;
              sb = pend_r;
              silence_nxt = sil_inc;
              hdr_enter = 1'b1;
            end else begin
              if (streamed) bend = xmr_pkg::BEND_DISCARD;
              pend_nxt  = xmr_pkg::B_NAK;
              phase_nxt = xmr_pkg::PH_PURGE;
            end
          end
        end
      end
      default: begin
        if (xmr_pkg::is_running(phase_r)) begin
          silence_nxt = 8'h00;
          case (phase_r)
            xmr_pkg::PH_HDR: begin
              if (in_rx_byte == xmr_pkg::B_EOT) begin
                sv = 1'b1;
                sb = xmr_pkg::B_ACK;
                phase_nxt = xmr_pkg::PH_OK;
              end else if (in_rx_byte == xmr_pkg::B_CAN) begin
                phase_nxt = xmr_pkg::PH_CANCEL;
              end else if (in_rx_byte == hdr_byte) begin
                phase_nxt = xmr_pkg::PH_BNUM;
              end else begin
                pend_nxt  = xmr_pkg::B_NAK;
                phase_nxt = xmr_pkg::PH_PURGE;
              end
            end
            xmr_pkg::PH_BNUM: begin
              rcv_blk_nxt = in_rx_byte;
              phase_nxt   = xmr_pkg::PH_BCMP;
            end
            xmr_pkg::PH_BCMP: begin
              if ((in_rx_byte ^ rcv_blk_r) != 8'hFF) begin
                pend_nxt  = xmr_pkg::B_NAK;
                phase_nxt = xmr_pkg::PH_PURGE;
              end else if (rcv_blk_r == exp_blk_r - 8'd1) begin
                // duplicate of the last block: ack it after the purge
                pend_nxt  = xmr_pkg::B_ACK;
                phase_nxt = xmr_pkg::PH_PURGE;
              end else if (rcv_blk_r != exp_blk_r) begin
                pend_nxt  = xmr_pkg::B_NAK;
                phase_nxt = xmr_pkg::PH_PURGE;
              end else begin
                phase_nxt    = xmr_pkg::PH_DATA;
                byte_cnt_nxt = 11'd0;
                crc_nxt      = 16'h0000;
                sum_nxt      = 8'h00;
              end
            end
            xmr_pkg::PH_DATA: begin
              dv = 1'b1;
              db = in_rx_byte;
              crc_nxt      = crc_new;
              sum_nxt      = sum_r + in_rx_byte;
              byte_cnt_nxt = cnt_inc;
              if (cnt_inc >= blk_size)
                phase_nxt = crc_mode ? xmr_pkg::PH_CRCHI : xmr_pkg::PH_CKLO;
            end
            xmr_pkg::PH_CRCHI: begin
              crc_hi_nxt = in_rx_byte;
              phase_nxt  = xmr_pkg::PH_CKLO;
            end
            xmr_pkg::PH_CKLO: begin
              if (ok) begin
                bend = xmr_pkg::BEND_COMMIT;
                sv = 1'b1;
                sb = xmr_pkg::B_ACK;
                good_nxt     = good_r + 16'd1;
                exp_blk_nxt  = exp_blk_r + 8'd1;
                att_base     = 8'h00;
                attempts_nxt = 8'h00;
                hdr_enter    = 1'b1;
              end else begin
                bend = xmr_pkg::BEND_DISCARD;
                pend_nxt  = xmr_pkg::B_NAK;
                phase_nxt = xmr_pkg::PH_PURGE;
              end
            end
            default: ;
          endcase
        end
      end
    endcase

    // header wait: abort once the attempt budget is spent
    if (hdr_enter) begin
      if (att_base == max_err_r) begin
        phase_nxt = xmr_pkg::PH_ERRORS;
      end else begin
        attempts_nxt = att_base + 8'd1;
        phase_nxt    = xmr_pkg::PH_HDR;
        silence_nxt  = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= xmr_pkg::PH_IDLE;
      exp_blk_r   <= 8'd1;
      rcv_blk_r   <= 8'd0;
      byte_cnt_r  <= 11'd0;
      crc_r       <= 16'h0000;
      sum_r       <= 8'h00;
      crc_hi_r    <= 8'h00;
      attempts_r  <= 8'h00;
      silence_r   <= 8'h00;
      pend_r      <= 8'h00;
      good_r      <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        exp_blk_r  <= exp_blk_nxt;
        rcv_blk_r  <= rcv_blk_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        crc_r      <= crc_nxt;
        sum_r      <= sum_nxt;
        crc_hi_r   <= crc_hi_nxt;
        attempts_r <= attempts_nxt;
        silence_r  <= silence_nxt;
        pend_r     <= pend_nxt;
        good_r     <= good_nxt;
      end
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sv_r       <= sv;
      sb_r       <= sb;
      dv_r       <= dv;
      db_r       <= db;
      bend_r     <= bend;
      st_r       <= xmr_pkg::phase_status(phase_nxt);
      good_out_r <= good_nxt;
      err_out_r  <= attempts_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_send_valid      = sv_r;
  assign out_send_byte       = sb_r;
  assign out_data_valid      = dv_r;
  assign out_data_byte       = db_r;
  assign out_block_end       = bend_r;
  assign out_transfer_status = st_r;
  assign out_good_blocks     = good_out_r;
  assign out_error_count     = err_out_r;

  a_data_while_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_transfer_status == xmr_pkg::ST_RUNNING)
    else $error("payload word outside a running transfer");

  a_commit_acks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end == xmr_pkg::BEND_COMMIT |->
      out_send_valid && out_send_byte == xmr_pkg::B_ACK)
    else $error("block commit without ack");

  a_commit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end == xmr_pkg::BEND_COMMIT |-> out_error_count <= 8'd1)
    else $error("attempts not cleared on commit");

  a_quiet_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_valid |-> out_send_byte == 8'h00)
    else $error("send byte set without send valid");

endmodule

FILE: verif/xmodem_receiver_top_tb.sv
`timescale 1ns / 1ps

module xmodem_receiver_top_tb;
  import xmr_pkg::*;

  localparam logic [7:0] MODE_SUM    = 8'd0;
  localparam logic [7:0] MODE_CRC    = 8'd1;
  localparam logic [7:0] MODE_1K     = 8'd2;
  localparam logic [7:0] MODE_1K_ALT = 8'd3;

  typedef struct packed {
    op_t        op;
    logic [7:0] b;
  } word_t;

  typedef struct packed {
    logic        send_v;
    logic [7:0]  send_b;
    logic        data_v;
    logic [7:0]  data_b;
    logic [1:0]  bend;
    logic [2:0]  status;
    logic [15:0] good;
    logic [7:0]  errs;
  } reply_t;

  typedef enum int {
    F_NONE, F_HDR, F_CMP, F_NUM, F_DUP, F_CHECK, F_TICK, F_CARRIER, F_RESTART, F_SHORT
  } fault_t;

  function automatic word_t mk(input op_t op, input logic [7:0] b);
    word_t w;
    w.op = op;
    w.b  = b;
    return w;
  endfunction

  class xfer_tracker;
    logic [1:0]  cfg_mode;
    logic [7:0]  hdr_limit, byte_limit, err_limit;
    phase_t      ph;
    logic [7:0]  blk_expect, blk_seen, crc_hi_byte, sum_run, tries, quiet_secs, held_reply;
    logic [10:0] data_cnt;
    logic [15:0] crc_run, blocks_ok;
    reply_t      replies_due[$];
    int          errors, live_words, checked, commits;

    function new();
      cfg_mode = MODE_CRC[1:0]; hdr_limit = 8'd10; byte_limit = 8'd2; err_limit = 8'd10;
      ph = PH_IDLE; blk_expect = 8'd1; blk_seen = 8'd0; data_cnt = '0; crc_run = '0;
      sum_run = '0; crc_hi_byte = '0; tries = '0; quiet_secs = '0; held_reply = '0;
      blocks_ok = '0;
      errors = 0; live_words = 0; checked = 0; commits = 0;
    endfunction

    function void set_reg(input reg_idx_t idx, input logic [7:0] v);
      case (idx)
        REG_MODE:       cfg_mode = v[1:0];
        REG_HDR_TMO:    hdr_limit = v;
        REG_BYTE_TMO:   byte_limit = v;
        REG_MAX_ERRORS: err_limit = v;
        default: ;
      endcase
    endfunction

    function logic is_crc();
      return cfg_mode != MODE_SUM[1:0];
    endfunction

    function logic [10:0] blk_len();
      return cfg_mode[1] ? BLK_SIZE_LONG : BLK_SIZE_SHORT;
    endfunction

    function logic [7:0] hello_byte();
      return is_crc() ? B_CRCREQ : B_NAK;
    endfunction

    function logic [7:0] frame_byte();
      return cfg_mode[1] ? B_STX : B_SOH;
    endfunction

    function logic busy();
      return ph >= PH_HDR && ph <= PH_PURGE;
    endfunction

    // a block whose payload has started going out
    function logic partial();
      return (ph == PH_DATA && data_cnt != 0) || ph == PH_CRCHI || ph == PH_CKLO;
    endfunction

    // bit-serial crc-16, msb first
    function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] x;
      logic fb;
      x = c;
      for (int k = 7; k >= 0; k--) begin
        fb = x[15] ^ d[k];
        x = {x[14:0], 1'b0};
        if (fb) x = x ^ CRC_POLY;
      end
      return x;
    endfunction

    function void await_header();
      if (tries == err_limit) begin
        ph = PH_ERRORS;
      end else begin
        tries = tries + 8'd1;
        ph = PH_HDR;
        quiet_secs = '0;
      end
    endfunction

    function void purge(input logic [7:0] reply);
      held_reply = reply;
      ph = PH_PURGE;
      quiet_secs = '0;
    endfunction

    function void take_word(input word_t w);
      reply_t r;
      logic [7:0] lim, prev;
      logic ok;
      r = '0;
      if (w.op == OP_START || busy()) live_words++;
      case (w.op)
        OP_START: begin
          if (partial()) r.bend = BEND_DISCARD;
          blk_expect = 8'd1; blk_seen = '0; data_cnt = '0; crc_run = '0; sum_run = '0;
          crc_hi_byte = '0; tries = '0; held_reply = '0; blocks_ok = '0;
          r.send_v = 1'b1;
          r.send_b = hello_byte();
          await_header();
        end
        OP_CARRIER: if (busy()) begin
          if (partial()) r.bend = BEND_DISCARD;
          r.send_v = 1'b1;
          if (ph == PH_HDR) r.send_b = hello_byte();
          else if (ph == PH_PURGE) r.send_b = held_reply;
          else r.send_b = B_NAK;
          ph = PH_CARRIER;
        end
        OP_TICK: if (busy()) begin
          lim = (ph == PH_HDR) ? hdr_limit : byte_limit;
          if (quiet_secs != 8'hFF) quiet_secs = quiet_secs + 8'd1;
          if (quiet_secs >= lim) begin
            if (ph == PH_HDR) begin
              purge(hello_byte());
            end else if (ph == PH_PURGE) begin
              r.send_v = 1'b1;
              r.send_b = held_reply;
              await_header();
            end else begin
              if (partial()) r.bend = BEND_DISCARD;
              purge(B_NAK);
            end
          end
        end
        OP_BYTE: if (busy()) begin
          quiet_secs = '0;
          case (ph)
            PH_HDR: begin
              if (w.b == B_EOT) begin
                r.send_v = 1'b1;
                r.send_b = B_ACK;
                ph = PH_OK;
              end else if (w.b == B_CAN) begin
                ph = PH_CANCEL;
              end else if (w.b == frame_byte()) begin
                ph = PH_BNUM;
              end else begin
                purge(B_NAK);
              end
            end
            PH_BNUM: begin
              blk_seen = w.b;
              ph = PH_BCMP;
            end
            PH_BCMP: begin
              prev = blk_expect - 8'd1;
              if ((w.b ^ blk_seen) != 8'hFF) purge(B_NAK);
              else if (blk_seen == prev) purge(B_ACK);
              else if (blk_seen != blk_expect) purge(B_NAK);
              else begin
                ph = PH_DATA;
                data_cnt = '0;
                crc_run = '0;
                sum_run = '0;
              end
            end
            PH_DATA: begin
              r.data_v = 1'b1;
              r.data_b = w.b;
              crc_run = crc_step(crc_run, w.b);
              sum_run = sum_run + w.b;
              data_cnt = data_cnt + 11'd1;
              if (data_cnt >= blk_len()) begin
                if (is_crc()) ph = PH_CRCHI;
                else ph = PH_CKLO;
              end
            end
            PH_CRCHI: begin
              crc_hi_byte = w.b;
              ph = PH_CKLO;
            end
            PH_CKLO: begin
              ok = is_crc() ? ({crc_hi_byte, w.b} == crc_run) : (w.b == sum_run);
              if (ok) begin
                r.bend = BEND_COMMIT;
                r.send_v = 1'b1;
                r.send_b = B_ACK;
                blocks_ok = blocks_ok + 16'd1;
                blk_expect = blk_expect + 8'd1;
                tries = '0;
                commits++;
                await_header();
              end else begin
                r.bend = BEND_DISCARD;
                purge(B_NAK);
              end
            end
            default: ;  // purging: byte dropped
          endcase
        end
        default: ;
      endcase
      if (ph == PH_IDLE) r.status = ST_IDLE;
      else if (busy()) r.status = ST_RUNNING;
      else if (ph == PH_OK) r.status = ST_SUCCESS;
      else if (ph == PH_CARRIER) r.status = ST_CARRIER;
      else if (ph == PH_ERRORS) r.status = ST_ERRORS;
      else r.status = ST_CANCELLED;
      r.good = blocks_ok;
      r.errs = tries;
      replies_due.push_back(r);
    endfunction

    function void cmp(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void match_reply(input reply_t got);
      reply_t want;
      checked++;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing pending, expected none actual %h", $time, got);
        return;
      end
      want = replies_due.pop_front();
      cmp("send_valid", 16'(want.send_v), 16'(got.send_v));
      cmp("send_byte", 16'(want.send_b), 16'(got.send_b));
      cmp("data_valid", 16'(want.data_v), 16'(got.data_v));
      cmp("data_byte", 16'(want.data_b), 16'(got.data_b));
      cmp("block_end", 16'(want.bend), 16'(got.bend));
      cmp("transfer_status", 16'(want.status), 16'(got.status));
      cmp("good_blocks", want.good, got.good);
      cmp("error_count", 16'(want.errs), 16'(got.errs));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_send_valid;
  logic [7:0]  out_send_byte;
  logic        out_data_valid;
  logic [7:0]  out_data_byte;
  logic [1:0]  out_block_end;
  logic [2:0]  out_transfer_status;
  logic [15:0] out_good_blocks;
  logic [7:0]  out_error_count;

  xfer_tracker sb = new();
  int tx_gap_pct = 25;
  int rx_stall_pct = 25;
  bit calm = 1'b0;
  int settings_tried = 0;

  xmodem_receiver_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_send_valid      (out_send_valid),
    .out_send_byte       (out_send_byte),
    .out_data_valid      (out_data_valid),
    .out_data_byte       (out_data_byte),
    .out_block_end       (out_block_end),
    .out_transfer_status (out_transfer_status),
    .out_good_blocks     (out_good_blocks),
    .out_error_count     (out_error_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[xmodem_receiver_top] ERROR");
    $finish;
  end

  // result side: random stalls plus one long hold-off to back the block up
  initial begin : rx_side
    int hold;
    bit pressed;
    reply_t got;
    hold = 0;
    pressed = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.send_v = out_send_valid;
        got.send_b = out_send_byte;
        got.data_v = out_data_valid;
        got.data_b = out_data_byte;
        got.bend   = out_block_end;
        got.status = out_transfer_status;
        got.good   = out_good_blocks;
        got.errs   = out_error_count;
        sb.match_reply(got);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!pressed && sb.checked >= 300 && in_valid) begin
        pressed = 1'b1;
        hold = 399;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        hold = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input op_t op, input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_word(mk(op, b));
  endtask

  task automatic settle();
    int w;
    in_valid <= 1'b0;
    w = 0;
    while (sb.replies_due.size() != 0 && w < 20000) begin
      @(posedge clk);
      w++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] md, input logic [7:0] hdr,
                           input logic [7:0] byt, input logic [7:0] maxe);
    reg_idx_t idx [4];
    logic [7:0] v [4];
    idx = '{REG_MODE, REG_HDR_TMO, REG_BYTE_TMO, REG_MAX_ERRORS};
    v = '{md, hdr, byt, maxe};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= v[i];
      @(posedge clk);
      sb.set_reg(idx[i], v[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_tried++;
  endtask

  // one framed block for the current expected number, maybe with one fault
  task automatic send_block(input int fault_pct);
    word_t q[$];
    logic [7:0] num, sum, d;
    logic [15:0] crc;
    int n, pos;
    fault_t kind;
    num = sb.blk_expect;
    n = int'(sb.blk_len());
    sum = '0;
    crc = '0;
    q.push_back(mk(OP_BYTE, sb.frame_byte()));
    q.push_back(mk(OP_BYTE, num));
    q.push_back(mk(OP_BYTE, ~num));
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom_range(0, 255));
      q.push_back(mk(OP_BYTE, d));
      sum = sum + d;
      crc = sb.crc_step(crc, d);
    end
    if (sb.is_crc()) begin
      q.push_back(mk(OP_BYTE, crc[15:8]));
      q.push_back(mk(OP_BYTE, crc[7:0]));
    end else begin
      q.push_back(mk(OP_BYTE, sum));
    end
    kind = F_NONE;
    if ($urandom_range(0, 99) < fault_pct) kind = fault_t'($urandom_range(F_HDR, F_SHORT));
    pos = $urandom_range(3, q.size() - 1);
    case (kind)
      F_HDR:     q[0].b = 8'($urandom_range(0, 255));
      F_CMP:     q[2].b = q[2].b ^ (8'h01 << $urandom_range(0, 7));
      F_NUM: begin
        q[1].b = num + 8'($urandom_range(1, 253));
        q[2].b = ~q[1].b;
      end
      F_DUP: begin
        q[1].b = num - 8'd1;
        q[2].b = ~q[1].b;
      end
      F_CHECK:   q[q.size() - 1].b = q[q.size() - 1].b ^ (8'h01 << $urandom_range(0, 7));
      F_TICK:    q.insert(pos, mk(OP_TICK, 8'($urandom_range(0, 255))));
      F_CARRIER: q.insert(pos, mk(OP_CARRIER, 8'($urandom_range(0, 255))));
      F_RESTART: q.insert(pos, mk(OP_START, 8'($urandom_range(0, 255))));
      F_SHORT:   while (q.size() > pos) q.pop_back();
      default: ;
    endcase
    foreach (q[i]) begin
      send_word(q[i].op, q[i].b);
      if (q[i].op == OP_CARRIER || q[i].op == OP_START) return;
      // mostly stop once the block is rejected, sometimes keep talking into the purge
      if ((sb.ph == PH_PURGE || sb.ph == PH_HDR || !sb.busy()) && $urandom_range(0, 3) != 0)
        return;
    end
  endtask

  task automatic play_session(input int n_blocks, input int fault_pct);
    int spent, left, r;
    send_word(OP_START, 8'($urandom_range(0, 255)));
    spent = 0;
    while (sb.busy()) begin
      spent++;
      if (spent > 400) begin
        send_word(OP_CARRIER, 8'($urandom_range(0, 255)));
        break;
      end
      left = n_blocks - int'(sb.blocks_ok);
      r = $urandom_range(0, 99);
      case (sb.ph)
        PH_HDR: begin
          if (left <= 0) begin
            if (r < 70) send_word(OP_BYTE, B_EOT);
            else if (r < 80) send_word(OP_BYTE, B_CAN);
            else if (r < 90) send_word(OP_CARRIER, 8'($urandom_range(0, 255)));
            else send_word(OP_START, 8'($urandom_range(0, 255)));
          end else if (r < 8) begin
            send_word(OP_TICK, 8'($urandom_range(0, 255)));
          end else if (r < 12) begin
            send_word(OP_BYTE, 8'($urandom_range(0, 255)));
          end else if (r < 14) begin
            send_word(OP_CARRIER, 8'($urandom_range(0, 255)));
          end else begin
            send_block(fault_pct);
          end
        end
        PH_PURGE: begin
          if (r < 10) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
          else send_word(OP_TICK, 8'($urandom_range(0, 255)));
        end
        default: send_word(OP_TICK, 8'($urandom_range(0, 255)));  // stalled mid-block
      endcase
    end
    // chatter the block ignores once the transfer is over
    repeat ($urandom_range(0, 3)) send_word(op_t'($urandom_range(OP_BYTE, OP_CARRIER)),
                                            8'($urandom_range(0, 255)));
  endtask

  initial begin : main
    int pct [3];
    pct = '{0, 15, 40};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = OP_START;
    in_rx_byte = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-on settings, a short walk through the corner cases
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'h00);
    send_word(OP_CARRIER, 8'hA5);
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, 8'h00);       // junk header starts a purge
    send_word(OP_CARRIER, 8'h00);    // held reply goes out at once
    send_word(OP_START, 8'hFF);
    send_word(OP_BYTE, B_EOT);
    send_word(OP_BYTE, B_CAN);       // ignored after success
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, B_CAN);
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, B_SOH);
    send_word(OP_BYTE, 8'h00);       // block 0 before the first block: duplicate
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, B_SOH);
    send_word(OP_BYTE, 8'h01);
    send_word(OP_BYTE, 8'h01);       // bad complement
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_CARRIER, 8'hFF);
    send_word(OP_START, 8'h00);
    send_word(OP_CARRIER, 8'h00);
    settle();

    write_cfg(MODE_CRC, 8'd3, 8'd2, 8'd10);
    play_session(2, 25);
    settle();

    write_cfg(MODE_SUM, 8'd1, 8'd1, 8'd3);
    play_session(1, 40);
    settle();

    write_cfg(MODE_1K, 8'd4, 8'd3, 8'd5);
    play_session(1, 0);
    settle();

    // mode 3 behaves as 1k, limits at their top
    write_cfg(MODE_1K_ALT, 8'd255, 8'd255, 8'd255);
    send_word(OP_START, 8'h3C);
    send_word(OP_BYTE, B_STX);
    send_word(OP_BYTE, 8'h01);
    send_word(OP_BYTE, 8'h5A);
    while (sb.ph == PH_PURGE) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    send_word(OP_BYTE, B_EOT);
    settle();

    // zero limits: no attempt allowed at all, then one attempt with instant timeouts
    write_cfg(MODE_SUM, 8'd0, 8'd0, 8'd0);
    send_word(OP_START, 8'h81);
    settle();
    write_cfg(MODE_SUM, 8'd0, 8'd0, 8'd1);
    play_session(1, 50);
    settle();

    while (sb.live_words < 1850) begin
      tx_gap_pct = pct[$urandom_range(0, 2)];
      rx_stall_pct = pct[$urandom_range(0, 2)];
      write_cfg(8'($urandom_range(MODE_SUM, MODE_CRC)), 8'($urandom_range(1, 6)),
                8'($urandom_range(1, 4)), 8'($urandom_range(2, 12)));
      repeat ($urandom_range(1, 3)) play_session($urandom_range(0, 2), 30);
      settle();
    end

    // closing stretch at full rate
    calm = 1'b1;
    write_cfg(MODE_CRC, 8'd2, 8'd1, 8'd10);
    play_session(1, 0);
    settle();

    $display("covered %0d protocol words and %0d result words, %0d blocks committed",
             sb.live_words, sb.checked, sb.commits);
    $display("%0d register settings, all four modes, limits down to 0 and up to 255",
             settings_tried);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("[xmodem_receiver_top] OK");
    end else begin
      if (sb.replies_due.size() != 0)
        $display("%0t: %0d result words never arrived", $time, sb.replies_due.size());
      $display("[xmodem_receiver_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: xmodem_receiver_top.f
rtl/xmr_pkg.sv
rtl/xmodem_receiver_top.sv
verif/xmodem_receiver_top_tb.sv
